>>> hdl/prr_pkg.sv
// Shared types and constants of the phase-adaptive RRIP replacement block.
`default_nettype none

package prr_pkg;

  // Request and response field widths
  localparam int SET_W   = 11;
  localparam int WAY_W   = 4;
  localparam int MASK_W  = 16;
  localparam int PHASE_W = 2;

  // Per-way, per-set and threshold field widths
  localparam int RRV_W = 2;
  localparam int UC_W  = 4;
  localparam int BIP_W = 5;
  localparam int THR_W = 6;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REGULAR_MIN_HITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_MAX_HITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIP_PERIOD       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_COUNT_MAX    = 2'd3;

  localparam logic [THR_W-1:0] RST_REGULAR_MIN_HITS = 6'd20;
  localparam logic [THR_W-1:0] RST_STREAM_MAX_HITS  = 6'd6;
  localparam logic [THR_W-1:0] RST_BIP_PERIOD       = 6'd32;
  localparam logic [UC_W-1:0]  RST_USE_COUNT_MAX    = 4'd15;

  localparam logic [THR_W-1:0] BIP_PERIOD_MAX = 6'd32;

  // Operations
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Set phases
  localparam logic [PHASE_W-1:0] PH_REGULAR   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_STREAM    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_IRREGULAR = 2'd2;

  // Re-reference values
  localparam logic [RRV_W-1:0] RRV_HIT   = 2'd0;
  localparam logic [RRV_W-1:0] RRV_LONG  = 2'd2;
  localparam logic [RRV_W-1:0] RRV_SHORT = 2'd3;

  typedef struct packed {
    logic [THR_W-1:0] regular_min_hits;
    logic [THR_W-1:0] stream_max_hits;
    logic [THR_W-1:0] bip_period;
    logic [UC_W-1:0]  use_count_max;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

>>> hdl/prr_ifs.sv
// Request and response channel interfaces of the replacement block.
`default_nettype none

interface prr_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [prr_pkg::SET_W-1:0]      set_index;
  logic [prr_pkg::WAY_W-1:0]      way_index;
  logic                           hit;
  logic [prr_pkg::MASK_W-1:0]     valid_mask;

  modport source (output valid, operation, set_index, way_index, hit, valid_mask,
                  input ready);
  modport sink (input valid, operation, set_index, way_index, hit, valid_mask,
                output ready);
endinterface

interface prr_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [prr_pkg::WAY_W-1:0]      victim_way;
  logic [prr_pkg::PHASE_W-1:0]    set_phase;

  modport source (output valid, victim_way, set_phase, input ready);
  modport sink (input valid, victim_way, set_phase, output ready);
endinterface

`default_nettype wire

>>> hdl/phase_adaptive_rrip_replacement.sv
// Top level of the phase-adaptive RRIP replacement policy.
//
// Usage: requests arrive on req (valid/ready). A victim request
// (operation 0) returns the way to evict for set_index given valid_mask;
// an update (operation 1) records a hit or miss fill for way_index and
// returns victim_way 0. Every request yields exactly one response on rsp
// with the set's phase after the request.
// Sequence: an accepted request reads the set memory in the read step and
// loads the response register in the execute step. One request is in
// flight at a time; the set memory's read-then-write turn keeps a new
// request from being taken before the current one writes back. The next
// request is taken in the same cycle the current one writes back, so a
// following request to the same set always reads updated state.
// Stall: the response register holds until rsp.ready. A request that
// finds the register still full waits in the execute step and takes no
// new request until the register is free.
// Reset: rst is synchronous. Afterwards the set memory is swept to its
// reset state, one set per cycle over all NUM_SETS sets, while req.ready
// stays low. The configuration port works throughout.
`default_nettype none

module phase_adaptive_rrip_replacement #(
  parameter int NUM_SETS   = 2048,
  parameter int NUM_WAYS   = 16,
  parameter int WINDOW_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  prr_req_if.sink                           req,
  prr_rsp_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [prr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [prr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [prr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int SW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SIN = prr_pkg::SET_W;
  localparam int PW  = $clog2(WINDOW_LEN);
  localparam int CW  = (PW + 1 > prr_pkg::THR_W) ? PW + 1 : prr_pkg::THR_W;
  localparam int WW  = prr_pkg::WAY_W;
  localparam int UW  = prr_pkg::UC_W;
  localparam int RW  = prr_pkg::RRV_W;
  localparam int BW  = prr_pkg::BIP_W;
  localparam int TW  = prr_pkg::THR_W;

  // One memory word per set. Re-reference values are kept inverted so
  // the all-zero word written by the clearing sweep means "all 3".
  typedef struct packed {
    logic [BW-1:0]                 bip;
    logic [prr_pkg::PHASE_W-1:0]   phase;
    logic [PW-1:0]                 hits;
    logic [PW-1:0]                 pos;
    logic [NUM_WAYS-1:0][UW-1:0]   use_cnt;
    logic [NUM_WAYS-1:0][RW-1:0]   rrv_n;
  } set_word_t;

  localparam int WORD_W = $bits(set_word_t);

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  prr_pkg::cfg_t cfg;

  prr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  prr_pkg::state_t state, state_next;

  logic req_ready;
  logic accept;
  logic out_free;
  logic out_load;
  logic out_valid;
  logic rd_en;
  logic wr_en;
  logic clearing;

  assign req.ready = req_ready;
  assign accept    = req.valid && req_ready;
  assign out_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      prr_pkg::ST_IDLE: begin
        req_ready = !clearing;
        if (req.valid && !clearing) begin
          state_next = prr_pkg::ST_READ;
        end
      end
      prr_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = prr_pkg::ST_EXEC;
      end
      prr_pkg::ST_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          wr_en      = (op_q == prr_pkg::OP_UPDATE);
          req_ready  = 1'b1;
          state_next = req.valid ? prr_pkg::ST_READ : prr_pkg::ST_IDLE;
        end
      end
      default: state_next = prr_pkg::ST_IDLE;
    endcase
  end

  // Request capture
  logic                      op_q;
  logic [SIN-1:0]            set_q;
  logic [WW-1:0]             way_q;
  logic                      hit_q;
  logic [prr_pkg::MASK_W-1:0] mask_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req.operation;
      set_q  <= req.set_index;
      way_q  <= req.way_index;
      hit_q  <= req.hit;
      mask_q <= req.valid_mask;
    end
  end

  // ---------------------------------------------------------------------
  // Set index modulo NUM_SETS
  // ---------------------------------------------------------------------
  logic [SW-1:0] set_red;
  logic [SW-1:0] set_r;

  if (NUM_SETS >= (1 << SIN)) begin : g_mod_none
    assign set_red = SW'(set_q);
  end else if ((NUM_SETS & (NUM_SETS - 1)) == 0) begin : g_mod_mask
    assign set_red = SW'(set_q) & SW'(NUM_SETS - 1);
  end else begin : g_mod_recip
    // Quotient by reciprocal multiply at accept, exact for 11-bit indexes;
    // remainder by constant multiply and subtract in the read cycle.
    localparam int K   = SIN + SW;
    localparam int MW  = K - SW + 1;
    localparam int PRW = SIN + MW;
    localparam int QW  = PRW - K;
    localparam longint unsigned RECIP = ((64'd1 << K) + NUM_SETS - 1) / NUM_SETS;

    logic [PRW-1:0] prod;
    logic [QW-1:0]  quot_q;

    assign prod = PRW'(req.set_index) * PRW'(RECIP);

    always_ff @(posedge clk) begin
      if (accept) begin
        quot_q <= prod[PRW-1:K];
      end
    end

    assign set_red = SW'(set_q - SIN'(quot_q * NUM_SETS));
  end

  always_ff @(posedge clk) begin
    if (state == prr_pkg::ST_READ) begin
      set_r <= set_red;
    end
  end

  // ---------------------------------------------------------------------
  // Set memory
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] rd_data;
  set_word_t         cur;
  set_word_t         nxt;

  prr_set_store #(
    .NUM_SETS (NUM_SETS),
    .WORD_W   (WORD_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (set_red),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (set_r),
    .wr_data  (nxt),
    .clearing (clearing)
  );

  assign cur = set_word_t'(rd_data);

  // ---------------------------------------------------------------------
  // Victim search
  // ---------------------------------------------------------------------
  logic [NUM_WAYS-1:0][RW-1:0] rrv_true;
  logic [WW-1:0]               pick;

  assign rrv_true = ~cur.rrv_n;

  prr_victim #(
    .NUM_WAYS (NUM_WAYS)
  ) u_victim (
    .rrv        (rrv_true),
    .use_cnt    (cur.use_cnt),
    .irregular  (cur.phase == prr_pkg::PH_IRREGULAR),
    .valid_mask (mask_q),
    .victim     (pick)
  );

  // ---------------------------------------------------------------------
  // Update: window count and phase, then promote or insert
  // ---------------------------------------------------------------------
  logic [PW:0]                 pos_inc;
  logic [PW:0]                 hits_inc;
  logic                        win_end;
  logic [prr_pkg::PHASE_W-1:0] phase_new;
  logic [TW-1:0]               period;
  logic [BW:0]                 bip_inc;
  logic [BW-1:0]               bip_wrap;
  logic [UW:0]                 cnt_inc;
  logic [RW-1:0]               ins_rrv;

  always_comb begin
    nxt      = cur;
    pos_inc  = {1'b0, cur.pos} + 1'b1;
    hits_inc = {1'b0, cur.hits} + (PW + 1)'(hit_q);
    win_end  = (pos_inc == (PW + 1)'(WINDOW_LEN));
    phase_new = cur.phase;
    cnt_inc  = '0;
    ins_rrv  = prr_pkg::RRV_SHORT;

    if (win_end) begin
      if (CW'(hits_inc) >= CW'(cfg.regular_min_hits)) begin
        phase_new = prr_pkg::PH_REGULAR;
      end else if (CW'(hits_inc) <= CW'(cfg.stream_max_hits)) begin
        phase_new = prr_pkg::PH_STREAM;
      end else begin
        phase_new = prr_pkg::PH_IRREGULAR;
      end
      nxt.pos  = '0;
      nxt.hits = '0;
    end else begin
      nxt.pos  = pos_inc[PW-1:0];
      nxt.hits = hits_inc[PW-1:0];
    end
    nxt.phase = phase_new;

    // zero acts as 1, anything above the maximum as the maximum
    if (cfg.bip_period == '0) begin
      period = TW'(1);
    end else if (cfg.bip_period > prr_pkg::BIP_PERIOD_MAX) begin
      period = prr_pkg::BIP_PERIOD_MAX;
    end else begin
      period = cfg.bip_period;
    end
    bip_inc  = {1'b0, cur.bip} + 1'b1;
    bip_wrap = (TW'(bip_inc) >= period) ? '0 : bip_inc[BW-1:0];

    case (phase_new)
      prr_pkg::PH_REGULAR: ins_rrv = prr_pkg::RRV_LONG;
      prr_pkg::PH_STREAM:  ins_rrv = (cur.bip == '0) ? prr_pkg::RRV_LONG
                                                      : prr_pkg::RRV_SHORT;
      default:             ins_rrv = prr_pkg::RRV_SHORT;
    endcase

    // a way index beyond the set touches no per-way state
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (w < (1 << WW) && way_q == WW'(w)) begin
        if (hit_q) begin
          cnt_inc        = {1'b0, cur.use_cnt[w]} + 1'b1;
          nxt.use_cnt[w] = (cnt_inc > {1'b0, cfg.use_count_max}) ? cfg.use_count_max
                                                                 : cnt_inc[UW-1:0];
          nxt.rrv_n[w]   = ~prr_pkg::RRV_HIT;
        end else begin
          nxt.use_cnt[w] = UW'(1);
          nxt.rrv_n[w]   = ~ins_rrv;
          if (phase_new == prr_pkg::PH_STREAM) begin
            nxt.bip = bip_wrap;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------
  logic [WW-1:0]               out_victim;
  logic [prr_pkg::PHASE_W-1:0] out_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (op_q == prr_pkg::OP_UPDATE) begin
        out_victim <= '0;
        out_phase  <= phase_new;
      end else begin
        out_victim <= pick;
        out_phase  <= cur.phase;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.victim_way = out_victim;
  assign rsp.set_phase  = out_phase;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("request taken during memory clearing");

  a_read_then_exec: assert property (@(posedge clk) disable iff (rst)
    state == prr_pkg::ST_READ |=> state == prr_pkg::ST_EXEC)
    else $error("memory read not followed by execute");

  a_exec_loads_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == prr_pkg::ST_EXEC && out_free) |=> rsp.valid)
    else $error("execute did not load the response");

  a_exec_waits_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == prr_pkg::ST_EXEC && !out_free) |=> state == prr_pkg::ST_EXEC)
    else $error("execute left while response register full");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.set_phase == prr_pkg::PH_REGULAR ||
                   rsp.set_phase == prr_pkg::PH_STREAM ||
                   rsp.set_phase == prr_pkg::PH_IRREGULAR))
    else $error("illegal phase code in response");

endmodule

`default_nettype wire

>>> hdl/prr_cfg_regs.sv
// APB-style configuration registers of the replacement block.
`default_nettype none

module prr_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [prr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [prr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [prr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output prr_pkg::cfg_t                     cfg
);

  localparam int DW = prr_pkg::CFG_DATA_W;

  logic [prr_pkg::CFG_IDX_W-1:0] reg_idx;
  logic                          wr;

  assign reg_idx = paddr[prr_pkg::CFG_ADDR_W-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.regular_min_hits <= prr_pkg::RST_REGULAR_MIN_HITS;
      cfg.stream_max_hits  <= prr_pkg::RST_STREAM_MAX_HITS;
      cfg.bip_period       <= prr_pkg::RST_BIP_PERIOD;
      cfg.use_count_max    <= prr_pkg::RST_USE_COUNT_MAX;
    end else if (wr) begin
      case (reg_idx)
        prr_pkg::REG_REGULAR_MIN_HITS: cfg.regular_min_hits <= pwdata[prr_pkg::THR_W-1:0];
        prr_pkg::REG_STREAM_MAX_HITS:  cfg.stream_max_hits  <= pwdata[prr_pkg::THR_W-1:0];
        prr_pkg::REG_BIP_PERIOD:       cfg.bip_period       <= pwdata[prr_pkg::THR_W-1:0];
        prr_pkg::REG_USE_COUNT_MAX:    cfg.use_count_max    <= pwdata[prr_pkg::UC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      prr_pkg::REG_REGULAR_MIN_HITS: prdata = DW'(cfg.regular_min_hits);
      prr_pkg::REG_STREAM_MAX_HITS:  prdata = DW'(cfg.stream_max_hits);
      prr_pkg::REG_BIP_PERIOD:       prdata = DW'(cfg.bip_period);
      prr_pkg::REG_USE_COUNT_MAX:    prdata = DW'(cfg.use_count_max);
      default:                       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/prr_set_store.sv
// Per-set state memory with a post-reset clearing sweep.
`default_nettype none

module prr_set_store #(
  parameter int NUM_SETS = 2048,
  parameter int WORD_W   = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [SW-1:0]       rd_addr,
  output logic [WORD_W-1:0]   rd_data,
  input  logic                wr_en,
  input  logic [SW-1:0]       wr_addr,
  input  logic [WORD_W-1:0]   wr_data,
  output logic                clearing
);

  localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  logic [WORD_W-1:0] mem [NUM_SETS];
  logic [SW-1:0]     clr_addr;

  // All-zero word is the reset state of a set.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == SW'(NUM_SETS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/prr_victim.sv
// Victim selection: first invalid way, else a reduction tree over the ways.
`default_nettype none

module prr_victim #(
  parameter int NUM_WAYS = 16
) (
  input  logic [NUM_WAYS-1:0][prr_pkg::RRV_W-1:0] rrv,
  input  logic [NUM_WAYS-1:0][prr_pkg::UC_W-1:0]  use_cnt,
  input  logic                                    irregular,
  input  logic [prr_pkg::MASK_W-1:0]              valid_mask,
  output logic [prr_pkg::WAY_W-1:0]               victim
);

  localparam int IW = $clog2(NUM_WAYS);
  localparam int P  = 1 << IW;
  localparam int NM = (NUM_WAYS < prr_pkg::MASK_W) ? NUM_WAYS : prr_pkg::MASK_W;
  localparam int WW = prr_pkg::WAY_W;

  // Heap-ordered tree: node i has children 2i+1 (lower ways) and 2i+2.
  logic                      n_vld [2*P-1];
  logic [IW-1:0]             n_idx [2*P-1];
  logic [prr_pkg::RRV_W-1:0] n_rrv [2*P-1];
  logic [prr_pkg::UC_W-1:0]  n_use [2*P-1];

  for (genvar l = 0; l < P; l++) begin : g_leaf
    if (l < NUM_WAYS) begin : g_way
      assign n_vld[P-1+l] = 1'b1;
      assign n_idx[P-1+l] = IW'(l);
      assign n_rrv[P-1+l] = rrv[l];
      assign n_use[P-1+l] = use_cnt[l];
    end else begin : g_pad
      assign n_vld[P-1+l] = 1'b0;
      assign n_idx[P-1+l] = '0;
      assign n_rrv[P-1+l] = '0;
      assign n_use[P-1+l] = '0;
    end
  end

  for (genvar i = 0; i < P - 1; i++) begin : g_node
    logic take_b;
    // regular/stream: last way with the largest value
    // irregular: smallest count, ties to a strictly larger value
    assign take_b = n_vld[2*i+2] &&
                    (!n_vld[2*i+1] ||
                     (irregular ? ((n_use[2*i+2] < n_use[2*i+1]) ||
                                   ((n_use[2*i+2] == n_use[2*i+1]) &&
                                    (n_rrv[2*i+2] > n_rrv[2*i+1])))
                                : (n_rrv[2*i+2] >= n_rrv[2*i+1])));
    assign n_vld[i] = n_vld[2*i+1] || n_vld[2*i+2];
    assign n_idx[i] = take_b ? n_idx[2*i+2] : n_idx[2*i+1];
    assign n_rrv[i] = take_b ? n_rrv[2*i+2] : n_rrv[2*i+1];
    assign n_use[i] = take_b ? n_use[2*i+2] : n_use[2*i+1];
  end

  logic          found;
  logic [WW-1:0] first;

  always_comb begin
    found = 1'b0;
    first = '0;
    for (int w = NM - 1; w >= 0; w--) begin
      if (!valid_mask[w]) begin
        found = 1'b1;
        first = WW'(w);
      end
    end
  end

  assign victim = found ? first : WW'(n_idx[0]);

endmodule

`default_nettype wire
